>>> hdl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg: shared types and constants for the process scheduler
// Holds payload structs, policy codes and the control/status structs.
// ----------------------------------------------------------------------------
package cps_pkg;

   localparam int QueueDepth = 16;
   localparam int IdxW = $clog2(QueueDepth);
   localparam int LenW = $clog2(QueueDepth + 1);

   localparam logic [1:0] POL_PRIO = 2'd0;
   localparam logic [1:0] POL_SRTF = 2'd1;

   localparam logic OP_ARRIVE   = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   localparam logic [0:0] CSR_POLICY  = 1'b0;
   localparam logic [0:0] CSR_QUANTUM = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] proc_id;
      logic [31:0] arrival_time;
      logic [15:0] total_burst;
      logic [15:0] given_remaining;
      logic [7:0]  prio;
      logic [31:0] now_time;
   } req_type;

   typedef struct packed {
      logic [15:0] run_id;
      logic [31:0] run_arrival;
      logic [15:0] run_total;
      logic [15:0] run_remaining;
      logic [7:0]  run_prio;
      logic [31:0] start_time;
      logic [31:0] end_time;
      logic        cpu_idle;
      logic [4:0]  ready_count;
      logic        overflow;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request
      logic decide;      // evaluate an arrival or an empty-list completion
      logic scan_start;  // reset the minimum search
      logic scan_step;   // compare one entry
      logic take_best;   // load the best entry as running
      logic shift_step;  // move one entry up
      logic finish;      // build the response
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_complete;
      logic list_empty;
      logic scan_done;
      logic shift_done;
   } sts_type;

endpackage

>>> hdl/cps_ctrl.sv
// ----------------------------------------------------------------------------
// cps_ctrl: scheduler sequencer
// Steps each item through capture, then decision or search and removal, then response.
// ----------------------------------------------------------------------------
module cps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cps_pkg::sts_type  sts,
   output cps_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_SCAN, ST_TAKE, ST_SHIFT, ST_DONE, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // A new item is taken only once the previous response has been accepted.
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!sts.is_complete) begin
               cmd.decide = 1'b1;
               state_in   = ST_DONE;
            end else if (sts.list_empty) begin
               cmd.decide = 1'b1;
               state_in   = ST_DONE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_TAKE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_TAKE: begin
            cmd.take_best = 1'b1;
            state_in      = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (sts.shift_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/cps_dp.sv
// ----------------------------------------------------------------------------
// cps_dp: scheduler datapath
// Running record, ready list, minimum search and arrival decision.
// ----------------------------------------------------------------------------
module cps_dp (
   input  logic              clock,
   input  logic              reset,
   input  cps_pkg::req_type  req_data,
   input  logic              csr_write,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_data,
   input  cps_pkg::cmd_type  cmd,
   output cps_pkg::sts_type  sts,
   output cps_pkg::rsp_type  rsp_data
);

   localparam int IW = cps_pkg::IdxW;
   localparam int LW = cps_pkg::LenW;

   logic [1:0]  policy_ff;
   logic [15:0] quantum_ff;
   cps_pkg::req_type req_ff;

   logic [15:0] q_id_ff   [cps_pkg::QueueDepth];
   logic [31:0] q_arr_ff  [cps_pkg::QueueDepth];
   logic [31:0] q_bur_ff  [cps_pkg::QueueDepth];
   logic [7:0]  q_pri_ff  [cps_pkg::QueueDepth];
   logic [LW-1:0] len_ff;

   logic [15:0] cur_id_ff;
   logic [31:0] cur_arr_ff, cur_bur_ff, cur_start_ff, cur_end_ff;
   logic [7:0]  cur_pri_ff;

   logic [LW-1:0] ptr_ff;
   logic [IW-1:0] best_ff;
   logic          ovf_ff;
   cps_pkg::rsp_type rsp_ff;

   logic rr, idle, full;
   assign rr   = policy_ff[1];
   assign idle = (cur_id_ff == '0) && (cur_arr_ff == '0);
   assign full = len_ff >= LW'(cps_pkg::QueueDepth);

   // Saturating end time.
   function automatic logic [31:0] sat_end(input logic [31:0] now, input logic [15:0] len);
      logic [32:0] s;
      s = {1'b0, now} + {17'd0, len};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // Remaining time of the running process at preemption, clamped.
   logic [32:0] elapsed;
   logic [33:0] rem_wide;
   logic [15:0] rem_clamp;
   assign elapsed  = {1'b0, req_ff.now_time} - {1'b0, cur_arr_ff};
   assign rem_wide = {18'd0, cur_bur_ff[15:0]} - {elapsed[32], elapsed};
   always_comb begin
      if (rem_wide[33]) begin
         rem_clamp = '0;
      end else if (rem_wide[32:16] != '0) begin
         rem_clamp = 16'hFFFF;
      end else begin
         rem_clamp = rem_wide[15:0];
      end
   end

   logic queue_new;
   always_comb begin
      if (rr) begin
         queue_new = 1'b1;
      end else if (policy_ff == cps_pkg::POL_PRIO) begin
         queue_new = req_ff.prio > cur_pri_ff;
      end else begin
         queue_new = req_ff.total_burst >= cur_bur_ff[31:16];
      end
   end

   // One comparison of the minimum search.
   logic [IW-1:0] pi;
   logic          better;
   assign pi = ptr_ff[IW-1:0];
   always_comb begin
      if (rr) begin
         better = q_arr_ff[pi] < q_arr_ff[best_ff];
      end else if (policy_ff == cps_pkg::POL_PRIO) begin
         better = q_pri_ff[pi] < q_pri_ff[best_ff];
      end else begin
         better = q_bur_ff[pi][31:16] < q_bur_ff[best_ff][31:16];
      end
   end

   logic [15:0] best_rem, best_len;
   assign best_rem = q_bur_ff[best_ff][31:16];
   assign best_len = (rr && quantum_ff < best_rem) ? quantum_ff : best_rem;

   logic [15:0] idle_len;
   assign idle_len = rr ? ((quantum_ff < req_ff.given_remaining) ? quantum_ff
                                                                   : req_ff.given_remaining)
                        : req_ff.total_burst;

   logic [LW-1:0] shift_nxt;
   assign shift_nxt = ptr_ff + LW'(1);

   assign sts.is_complete = (req_ff.opcode == cps_pkg::OP_COMPLETE);
   assign sts.list_empty  = (len_ff == '0);
   assign sts.scan_done   = (ptr_ff >= len_ff);
   assign sts.shift_done  = (shift_nxt >= len_ff);
   assign rsp_data        = rsp_ff;

   // Configuration and request capture.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff  <= cps_pkg::POL_PRIO;
         quantum_ff <= 16'd10;
      end else if (csr_write) begin
         unique case (csr_index)
            cps_pkg::CSR_POLICY:  policy_ff  <= csr_data[1:0];
            cps_pkg::CSR_QUANTUM: quantum_ff <= csr_data;
            default: ;
         endcase
      end
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   // Ready list storage: pushed at the tail, shifted up one entry a cycle.
   logic [IW-1:0] tail, sp;
   assign tail = len_ff[IW-1:0];
   assign sp   = ptr_ff[IW-1:0];
   always_ff @(posedge clock) begin
      if (cmd.decide && !sts.is_complete && !idle && !full) begin
         if (queue_new) begin
            q_id_ff[tail]  <= req_ff.proc_id;
            q_arr_ff[tail] <= req_ff.arrival_time;
            q_bur_ff[tail] <= {(rr ? req_ff.given_remaining : req_ff.total_burst),
                               req_ff.total_burst};
            q_pri_ff[tail] <= req_ff.prio;
         end else begin
            q_id_ff[tail]  <= cur_id_ff;
            q_arr_ff[tail] <= cur_arr_ff;
            q_bur_ff[tail] <= {rem_clamp, cur_bur_ff[15:0]};
            q_pri_ff[tail] <= cur_pri_ff;
         end
      end
      if (cmd.shift_step) begin
         q_id_ff[sp]  <= q_id_ff[shift_nxt[IW-1:0]];
         q_arr_ff[sp] <= q_arr_ff[shift_nxt[IW-1:0]];
         q_bur_ff[sp] <= q_bur_ff[shift_nxt[IW-1:0]];
         q_pri_ff[sp] <= q_pri_ff[shift_nxt[IW-1:0]];
      end
   end

   // Running record, list length, search pointer and response.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         cur_id_ff    <= '0;
         cur_arr_ff   <= '0;
         cur_bur_ff   <= '0;
         cur_pri_ff   <= '0;
         cur_start_ff <= '0;
         cur_end_ff   <= '0;
         ptr_ff       <= '0;
         best_ff      <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         if (cmd.capture) begin
            ovf_ff <= 1'b0;
         end
         if (cmd.decide) begin
            if (sts.is_complete) begin
               cur_id_ff    <= '0;
               cur_arr_ff   <= '0;
               cur_bur_ff   <= '0;
               cur_pri_ff   <= '0;
               cur_start_ff <= '0;
               cur_end_ff   <= '0;
            end else if (idle || !queue_new) begin
               if (!idle && full) begin
                  ovf_ff <= 1'b1;
               end else begin
                  if (!idle) begin
                     len_ff <= len_ff + LW'(1);
                  end
                  cur_id_ff    <= req_ff.proc_id;
                  cur_arr_ff   <= req_ff.arrival_time;
                  cur_bur_ff   <= {req_ff.total_burst, req_ff.total_burst};
                  cur_pri_ff   <= req_ff.prio;
                  cur_start_ff <= req_ff.now_time;
                  cur_end_ff   <= sat_end(req_ff.now_time,
                                          idle ? idle_len : req_ff.total_burst);
               end
            end else if (full) begin
               ovf_ff <= 1'b1;
            end else begin
               len_ff <= len_ff + LW'(1);
            end
         end
         if (cmd.scan_start) begin
            ptr_ff  <= LW'(1);
            best_ff <= '0;
         end
         if (cmd.scan_step) begin
            if (better) begin
               best_ff <= pi;
            end
            ptr_ff <= ptr_ff + LW'(1);
         end
         if (cmd.take_best) begin
            cur_id_ff    <= q_id_ff[best_ff];
            cur_arr_ff   <= q_arr_ff[best_ff];
            cur_bur_ff   <= q_bur_ff[best_ff];
            cur_pri_ff   <= q_pri_ff[best_ff];
            cur_start_ff <= req_ff.now_time;
            cur_end_ff   <= sat_end(req_ff.now_time, best_len);
            ptr_ff       <= LW'(best_ff);
         end
         if (cmd.shift_step) begin
            ptr_ff <= shift_nxt;
         end
         if (cmd.finish && sts.is_complete && !sts.list_empty) begin
            len_ff <= len_ff - LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff.run_id        <= cur_id_ff;
         rsp_ff.run_arrival   <= cur_arr_ff;
         rsp_ff.run_total     <= cur_bur_ff[15:0];
         rsp_ff.run_remaining <= cur_bur_ff[31:16];
         rsp_ff.run_prio      <= cur_pri_ff;
         rsp_ff.start_time    <= cur_start_ff;
         rsp_ff.end_time      <= cur_end_ff;
         rsp_ff.cpu_idle      <= idle;
         rsp_ff.ready_count   <= 5'((sts.is_complete && !sts.list_empty)
                                    ? len_ff - LW'(1) : len_ff);
         rsp_ff.overflow      <= ovf_ff;
      end
   end

endmodule

>>> hdl/cpu_process_scheduler.sv
// ----------------------------------------------------------------------------
// cpu_process_scheduler: preemptive priority / SRTF / round robin scheduler
// Keeps the running process and a ready list of sixteen entries.
// ----------------------------------------------------------------------------
// Flow: an arrival, or a completion with an empty list, passes from the decode
// state through the done and out states to the response. A completion with
// entries listed goes through the search, take and shift states before done:
// the search compares one entry a cycle and removal shifts the later entries
// up one a cycle. One item is in work at a time; the next is taken once the
// response has been accepted. Reset clears the running record, the list
// length and the configuration (priority policy, quantum 10); list entries
// need no clearing.
// ----------------------------------------------------------------------------
module cpu_process_scheduler (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cps_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cps_pkg::rsp_type  rsp_data,
   input  logic              csr_write,
   input  logic [0:0]        csr_index,
   input  logic [15:0]       csr_data
);

   cps_pkg::cmd_type cmd;
   cps_pkg::sts_type sts;

   // The sequencer owns the handshakes and steps the datapath.
   cps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds all scheduling state and the response register.
   cps_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

   // The ready count never exceeds the list depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.ready_count <= 5'(cps_pkg::QueueDepth))
      else $error("ready count above list depth");

   // An overflow response reports no change in list length against a full list.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |->
         rsp_data.ready_count == 5'(cps_pkg::QueueDepth))
      else $error("overflow without a full list");

   // An idle response carries the null identity.
   a_idle_null: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.cpu_idle) |->
         (rsp_data.run_id == '0 && rsp_data.run_arrival == '0))
      else $error("idle flag with a running process");

   // No new item is taken in the cycle after one is accepted.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted during work");

endmodule
